>>> rtl/core/piq_pkg.sv
`timescale 1ns / 1ps

package piq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = CNT_W + 8;
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_POP    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] name_id;
    logic [7:0]  position;
    logic [3:0]  term;
  } piq_in_t;

  typedef struct packed {
    logic        pop_valid;
    logic [31:0] pop_name_id;
    logic [7:0]  pop_position;
    logic [3:0]  pop_term;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic [1:0]  status;
  } piq_out_t;

  typedef struct packed {
    logic [31:0] name_id;
    logic [7:0]  position;
    logic [3:0]  term;
  } piq_rec_t;

  typedef struct packed {
    logic load;
    logic exec;
  } piq_ctrl_t;

endpackage

>>> rtl/core/piq_ctrl.sv
`timescale 1ns / 1ps

module piq_ctrl
  import piq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output piq_ctrl_t ctrl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    ctrl.load = start && (state == S_IDLE);
    ctrl.exec = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/piq_dp.sv
`timescale 1ns / 1ps

module piq_dp
  import piq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  piq_ctrl_t ctrl,
  input  piq_in_t   cmd,
  output piq_out_t  result
);

  piq_in_t          cmd_q;
  piq_rec_t         rec;
  piq_rec_t         slots [DEPTH];
  piq_rec_t         slot_prev [DEPTH];
  piq_rec_t         slot_after [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] at;
  logic             full;
  logic             empty;
  logic             do_ins;
  logic             do_pop;
  status_t          status_next;

  assign rec = '{name_id: cmd_q.name_id, position: cmd_q.position, term: cmd_q.term};

  for (genvar g = 0; g < DEPTH; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign slot_prev[g] = rec;
    end else begin : g_rest
      assign slot_prev[g] = slots[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign slot_after[g] = slots[g];
    end else begin : g_mid
      assign slot_after[g] = slots[g+1];
    end
  end

  always_comb begin
    full        = (count == CNT_W'(DEPTH));
    empty       = (count == '0);
    do_ins      = 1'b0;
    do_pop      = 1'b0;
    at          = '0;
    status_next = ST_OK;
    case (cmd_q.kind)
      KIND_APPEND, KIND_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (cmd_q.kind == KIND_APPEND) begin
          do_ins = 1'b1;
          at     = IDX_W'(count);
        end else if (empty) begin
          do_ins = 1'b1;
        end else if (cmd_q.position == '0) begin
          status_next = ST_BAD_POS;
        end else if (CMP_W'(cmd_q.position) > CMP_W'(count)) begin
          do_ins = 1'b1;
          at     = IDX_W'(count);
        end else begin
          do_ins = 1'b1;
          at     = IDX_W'(cmd_q.position - 8'd1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_next = ST_POP_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_ins) begin
          if (IDX_W'(i) == at) begin
            slots[i] <= rec;
          end else if (IDX_W'(i) > at) begin
            slots[i] <= slot_prev[i];
          end
        end else if (do_pop) begin
          slots[i] <= slot_after[i];
        end
      end
      result.pop_valid    <= do_pop;
      result.pop_name_id  <= do_pop ? slots[0].name_id : '0;
      result.pop_position <= do_pop ? slots[0].position : '0;
      result.pop_term     <= do_pop ? slots[0].term : '0;
      result.occupancy    <= OCC_W'(count_next);
      result.is_empty     <= (count_next == '0);
      result.status       <= status_next;
    end
  end

endmodule

>>> rtl/core/positional_insert_queue_unit.sv
`timescale 1ns / 1ps

// Ordered record queue with append, positional insert and head pop. A
// command is taken when start is high and busy is low; it is first
// captured into the command register, then the slot shift register keeps,
// shifts or loads every slot at once. Its result appears on result, marked
// by done, which is high for exactly one cycle, in the cycle busy falls;
// the receiver cannot stall it, so sample result whenever done is high.
// A new command may be started in that same cycle. Every command yields
// exactly one result transaction carrying occupancy, empty flag and status.
module positional_insert_queue_unit
  import piq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  piq_in_t  cmd,
  output logic     done,
  output piq_out_t result
);

  piq_ctrl_t ctrl;

  piq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  piq_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cmd    (cmd),
    .result (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("command did not complete in one execute cycle");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.pop_valid) |-> (result.status == ST_OK))
    else $error("popped record reported with error status");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_POP_EMPTY)) |-> (result.is_empty && !result.pop_valid))
    else $error("pop on empty with records held");

endmodule

>>> sim/tb_positional_insert_queue_unit.sv
`timescale 1ns / 1ps

module tb_positional_insert_queue_unit;
  import piq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1900;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  class piq_scoreboard;
    piq_rec_t slots[DEPTH];
    int unsigned held;
    piq_out_t pending_q[$];
    int unsigned errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void shift_in(int unsigned at, piq_rec_t rec);
      for (int unsigned i = held; i > at; i--) slots[i] = slots[i - 1];
      slots[at] = rec;
      held++;
    endfunction

    function void note_cmd(piq_in_t c);
      piq_out_t r;
      piq_rec_t rec;
      r = '0;
      rec.name_id = c.name_id;
      rec.position = c.position;
      rec.term = c.term;
      if (c.kind == KIND_APPEND || c.kind == KIND_INSERT) begin
        if (held >= DEPTH) r.status = ST_FULL;
        else if (c.kind == KIND_APPEND) shift_in(held, rec);
        else if (held == 0) shift_in(0, rec);
        else if (c.position == 0) r.status = ST_BAD_POS;
        else if (c.position > held) shift_in(held, rec);
        else shift_in(c.position - 1, rec);
      end else if (c.kind == KIND_POP) begin
        if (held == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          r.pop_valid = 1'b1;
          r.pop_name_id = slots[0].name_id;
          r.pop_position = slots[0].position;
          r.pop_term = slots[0].term;
          for (int unsigned i = 1; i < held; i++) slots[i - 1] = slots[i];
          held--;
        end
      end
      r.occupancy = 5'(held);
      r.is_empty = (held == 0);
      pending_q.push_back(r);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(piq_out_t got);
      piq_out_t want;
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      cmp("pop_valid", want.pop_valid, got.pop_valid);
      cmp("pop_name_id", want.pop_name_id, got.pop_name_id);
      cmp("pop_position", want.pop_position, got.pop_position);
      cmp("pop_term", want.pop_term, got.pop_term);
      cmp("occupancy", want.occupancy, got.occupancy);
      cmp("is_empty", want.is_empty, got.is_empty);
      cmp("status", want.status, got.status);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  piq_in_t cmd;
  logic done;
  piq_out_t result;

  piq_scoreboard sb;
  bit steady;
  int unsigned cycles = 0;

  positional_insert_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_cmd(cmd);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("positional_insert_queue_unit regression: fail");
      $finish;
    end
  end

  function automatic piq_in_t mk(logic [1:0] k, logic [31:0] n, logic [7:0] p,
                                 logic [3:0] t);
    piq_in_t c;
    c.kind = k;
    c.name_id = n;
    c.position = p;
    c.term = t;
    return c;
  endfunction

  function automatic piq_in_t random_cmd(mix_t mix);
    int unsigned roll;
    int unsigned append_lim;
    int unsigned insert_lim;
    logic [1:0] k;
    logic [7:0] p;
    case (mix)
      MIX_FILL: begin
        append_lim = 35;
        insert_lim = 80;
      end
      MIX_DRAIN: begin
        append_lim = 12;
        insert_lim = 32;
      end
      default: begin
        append_lim = 38;
        insert_lim = 60;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < append_lim) k = KIND_APPEND;
    else if (roll < insert_lim) k = KIND_INSERT;
    else if (roll < 97) k = KIND_POP;
    else k = KIND_UNUSED;
    case ($urandom_range(0, 9))
      0: p = 8'd0;
      1: p = 8'd1;
      2: p = 8'(sb.held);
      3: p = 8'(sb.held + 1);
      4: p = 8'd255;
      5, 6, 7: p = 8'($urandom_range(1, sb.held + 1));
      default: p = 8'($urandom_range(0, 255));
    endcase
    return mk(k, $urandom, p, 4'($urandom_range(0, 15)));
  endfunction

  task automatic send(piq_in_t c);
    if (!steady) begin
      while ($urandom_range(0, 99) < 34) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    cmd <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every outstanding transaction has returned its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    piq_in_t c;
    int unsigned sent;
    int unsigned mix_left;
    mix_t mix;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send(mk(KIND_POP, 32'h1234_5678, 8'd3, 4'd2));
    send(mk(KIND_INSERT, 32'hFFFF_FFFF, 8'd0, 4'd15));
    send(mk(KIND_INSERT, 32'hDEAD_BEEF, 8'd0, 4'd7));
    send(mk(KIND_INSERT, 32'h0000_0000, 8'd1, 4'd0));
    send(mk(KIND_INSERT, 32'hA5A5_5A5A, 8'd255, 4'd9));
    send(mk(KIND_INSERT, 32'h0F0F_F0F0, 8'd2, 4'd5));
    send(mk(KIND_APPEND, 32'h8000_0001, 8'd128, 4'd8));
    send(mk(KIND_UNUSED, 32'h5555_AAAA, 8'd1, 4'd1));
    for (int i = 0; i < 11; i++) send(mk(KIND_APPEND, $urandom, 8'(i + 3), 4'(i)));
    send(mk(KIND_APPEND, 32'h7777_7777, 8'd7, 4'd3));
    send(mk(KIND_INSERT, 32'h3333_3333, 8'd0, 4'd3));
    send(mk(KIND_POP, 32'h0, 8'd0, 4'd0));
    send(mk(KIND_POP, 32'h0, 8'd0, 4'd0));
    send(mk(KIND_INSERT, 32'hCAFE_F00D, 8'd14, 4'd12));
    drain();

    sent = 0;
    mix_left = 0;
    mix = MIX_EVEN;
    while (sent < RANDOM_ITEMS) begin
      if (mix_left == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        mix_left = $urandom_range(20, 80);
      end
      mix_left--;
      steady = (sent >= 800 && sent < 1150);
      c = random_cmd(mix);
      send(c);
      if (c.kind != KIND_UNUSED) begin
        sent++;
        if (sent % 300 == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("positional_insert_queue_unit regression: pass");
    end else begin
      $display("positional_insert_queue_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/piq_pkg.sv
rtl/core/piq_ctrl.sv
rtl/core/piq_dp.sv
rtl/core/positional_insert_queue_unit.sv
sim/tb_positional_insert_queue_unit.sv
